### hdl/modulated_comb_allpass_reverb_core_assert.svh
// assertion macros shared by the reverb core
`ifndef MODULATED_COMB_ALLPASS_REVERB_CORE_ASSERT_SVH
`define MODULATED_COMB_ALLPASS_REVERB_CORE_ASSERT_SVH

// same-cycle implication
`define MCAR_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("mcar implication failed");

// next-cycle implication
`define MCAR_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("mcar sequence failed");

`endif

### hdl/mcar_pkg.sv
package mcar_pkg;

	localparam int SW = 24;
	localparam int ACC_W = 64;
	localparam int MB_W = 32;
	localparam int NB_W = 6;
	localparam int AP_W = 30;
	localparam int SUM_W = 28;
	localparam int EARLY_TAPS = 8;
	localparam int COMB_COUNT = 6;
	localparam int DIFF_COUNT = 3;
	localparam int EARLY_DEPTH = 13152;
	localparam int COMB_DEPTH = 12428;
	localparam int DIFF_DEPTH = 988;
	localparam int CLR_W = 14;
	localparam int EA_W = 14;
	localparam int CA_W = 14;
	localparam int DA_W = 10;
	localparam int PTR_W = 12;
	localparam int DPTR_W = 9;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int DIV6_SHIFT = 29;
	localparam int FB_BASE = 26214;

	localparam logic [CFG_IDX_W-1:0] CFG_ROOM_SIZE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DRY_WET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DAMPING = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EARLY_LEVEL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ALLPASS_GAIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MOD_DEPTH = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MOD_STEP = 3'd6;

	localparam logic [MB_W-1:0] ROOM_MUL = 32'd29491;
	localparam logic [MB_W-1:0] DIV6_RECIP = 32'd89478486;
	localparam logic signed [ACC_W-1:0] FS_MAX = 64'sd8388607;
	localparam logic signed [ACC_W-1:0] FS_MIN = -64'sd8388608;

	localparam logic [EA_W-1:0] EBASE [EARLY_TAPS] = '{
		14'd0, 14'd624, 14'd1536, 14'd2640, 14'd4032, 14'd5808, 14'd7872, 14'd10320};
	localparam logic [PTR_W-1:0] ELEN [EARLY_TAPS] = '{
		12'd624, 12'd912, 12'd1104, 12'd1392, 12'd1776, 12'd2064, 12'd2448, 12'd2832};
	localparam logic [MB_W-1:0] EATT [EARLY_TAPS] = '{
		32'd45875, 32'd42598, 32'd39322, 32'd36045,
		32'd32768, 32'd29491, 32'd26214, 32'd22938};
	localparam logic [CA_W-1:0] CBASE [COMB_COUNT] = '{
		14'd0, 14'd1425, 14'd3205, 14'd5177, 14'd7274, 14'd9688};
	localparam logic [PTR_W-1:0] CLEN [COMB_COUNT] = '{
		12'd1425, 12'd1780, 12'd1972, 12'd2097, 12'd2414, 12'd2740};
	localparam logic [DA_W-1:0] DBASE [DIFF_COUNT] = '{10'd0, 10'd240, 10'd667};
	localparam logic [DPTR_W-1:0] DLEN [DIFF_COUNT] = '{9'd240, 9'd427, 9'd321};
	localparam logic [31:0] LFO_INIT [COMB_COUNT] = '{
		32'd0, 32'd715827882, 32'd1431655765,
		32'd2147483648, 32'd2863311530, 32'd3579139413};
	localparam logic signed [16:0] QSINE [17] = '{
		17'sd0, 17'sd3212, 17'sd6393, 17'sd9512, 17'sd12540, 17'sd15447,
		17'sd18205, 17'sd20788, 17'sd23170, 17'sd25330, 17'sd27246, 17'sd28899,
		17'sd30274, 17'sd31357, 17'sd32138, 17'sd32610, 17'sd32768};

	typedef struct packed {
		logic [15:0] room_size;
		logic [15:0] dry_wet;
		logic [15:0] damping;
		logic [15:0] early_level;
		logic [15:0] allpass_gain;
		logic [9:0]  mod_depth;
		logic [31:0] mod_step;
	} cfg_t;

	typedef struct packed {
		logic                    start;
		logic signed [ACC_W-1:0] a;
		logic [MB_W-1:0]         b;
		logic [NB_W-1:0]         nb;
	} mul_req_t;

	typedef struct packed {
		logic                 load;
		logic signed [SW-1:0] sample;
	} res_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_FB_W, ST_E_RD, ST_E_W,
		ST_A_RD, ST_A_D, ST_A_W1, ST_A_W2,
		ST_C_SIN, ST_C_SIN_W, ST_C_OFF_W, ST_C_RDA, ST_C_RDB, ST_C_INT,
		ST_C_INT_W, ST_C_LP_W, ST_C_FB_W,
		ST_T_DIV_W, ST_M_EL_W, ST_M_MIX_W, ST_M_OUT
	} state_t;

	function automatic logic signed [ACC_W-1:0] rnd(input logic signed [ACC_W-1:0] v,
		input int n);
		logic signed [ACC_W-1:0] half;
		half = 64'sd1 <<< (n - 1);
		return (v + half) >>> n;
	endfunction

	function automatic logic signed [SW-1:0] sat(input logic signed [ACC_W-1:0] v);
		if (v > FS_MAX) begin
			return FS_MAX[SW-1:0];
		end else if (v < FS_MIN) begin
			return FS_MIN[SW-1:0];
		end
		return v[SW-1:0];
	endfunction

endpackage

### hdl/mcar_ram.sv
module mcar_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hdl/mcar_mul.sv
module mcar_mul (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mcar_pkg::mul_req_t               req,
	output logic                             busy,
	output logic signed [mcar_pkg::ACC_W-1:0] prod
);
	import mcar_pkg::*;

	logic [NB_W-1:0]         cnt_q;
	logic signed [ACC_W-1:0] a_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [MB_W-1:0]         b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= req.nb;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// shift-add, one multiplier bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q   <= req.a;
			b_q   <= req.b;
		end else if (cnt_q != '0) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q <<< 1;
			b_q <= b_q >> 1;
		end
	end

	assign busy = (cnt_q != '0);
	assign prod = acc_q;

endmodule

### hdl/mcar_seq.sv
`include "modulated_comb_allpass_reverb_core_assert.svh"

module mcar_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mcar_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [mcar_pkg::SW-1:0] sample_in,
	input  logic                          out_free,
	output mcar_pkg::res_t                res
);
	import mcar_pkg::*;

	state_t state_q, state_d;
	logic [2:0]       j_q;
	logic [1:0]       k_q;
	logic [CLR_W-1:0] clr_q;

	logic signed [SW-1:0]    x_q, d_q, a_q, rd_q, early_q;
	logic signed [SUM_W-1:0] eacc_q, tacc_q;
	logic signed [AP_W-1:0]  ap_q, y_q;
	logic [15:0]             fb_q;
	logic [PTR_W-1:0]        ia_q, ib_q;
	logic [7:0]              fr_q;

	logic [PTR_W-1:0]     eptr_q [EARLY_TAPS];
	logic [PTR_W-1:0]     cptr_q [COMB_COUNT];
	logic [DPTR_W-1:0]    dptr_q [DIFF_COUNT];
	logic signed [SW-1:0] lp_q [COMB_COUNT];
	logic [31:0]          ph_q [COMB_COUNT];

	mul_req_t                mul_req;
	logic                    mul_busy;
	logic signed [ACC_W-1:0] prod, p16, p15, p8;

	logic            e_we, c_we, d_we;
	logic [EA_W-1:0] e_waddr, e_raddr;
	logic [CA_W-1:0] c_waddr, c_raddr;
	logic [DA_W-1:0] d_waddr, d_raddr;
	logic [SW-1:0]   e_wdata, c_wdata, d_wdata, e_rdata, c_rdata, d_rdata;

	logic [PTR_W-1:0]        e_nptr, c_ptr, c_nptr, ia_n, ib_n;
	logic [DPTR_W-1:0]       d_nptr;
	logic signed [SUM_W-1:0] esum, esum_adj, tmag;
	logic signed [SW-1:0]    eavg, lpn;
	logic [1:0]              quad;
	logic [30:0]             r0, r1;
	logic [3:0]              sidx;
	logic [15:0]             sfrac;
	logic signed [17:0]      sdiff, sval, ssin;
	logic signed [11:0]      off;
	logic signed [21:0]      pos0, span, pos;
	logic signed [ACC_W-1:0] yn, wet, tq;
	logic                    accept, last_clr;

	mcar_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.busy   (mul_busy),
		.prod   (prod)
	);

	mcar_ram #(.WIDTH(SW), .DEPTH(EARLY_DEPTH)) u_early_ram (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata)
	);

	mcar_ram #(.WIDTH(SW), .DEPTH(COMB_DEPTH)) u_comb_ram (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(c_raddr), .rdata(c_rdata)
	);

	mcar_ram #(.WIDTH(SW), .DEPTH(DIFF_DEPTH)) u_diff_ram (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(d_raddr), .rdata(d_rdata)
	);

	assign p16 = rnd(prod, 16);
	assign p15 = rnd(prod, 15);
	assign p8  = rnd(prod, 8);

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign last_clr = (clr_q == CLR_W'(EARLY_DEPTH - 1));

	always_comb begin
		e_raddr  = EBASE[j_q] + EA_W'(eptr_q[j_q]);
		e_nptr   = (eptr_q[j_q] + 1'b1 == ELEN[j_q]) ? '0 : eptr_q[j_q] + 1'b1;
		esum     = eacc_q + SUM_W'($signed(e_rdata));
		esum_adj = esum + $signed({{(SUM_W-3){1'b0}}, {3{esum[SUM_W-1]}}});
		eavg     = SW'(esum_adj >>> 3);

		d_raddr = DBASE[k_q] + DA_W'(dptr_q[k_q]);
		d_nptr  = (dptr_q[k_q] + 1'b1 == DLEN[k_q]) ? '0 : dptr_q[k_q] + 1'b1;
		yn      = p16 + ACC_W'(d_q) - ACC_W'(ap_q);

		quad  = ph_q[j_q][31:30];
		r0    = {1'b0, ph_q[j_q][29:0]};
		r1    = quad[0] ? (31'h40000000 - r0) : r0;
		sidx  = r1[29:26];
		sfrac = r1[25:10];
		sdiff = 18'(QSINE[5'(sidx) + 5'd1]) - 18'(QSINE[5'(sidx)]);
		sval  = r1[30] ? 18'sd32768 : 18'(QSINE[5'(sidx)]) + 18'(p16);
		ssin  = quad[1] ? -sval : sval;

		c_ptr  = cptr_q[j_q];
		c_nptr = (c_ptr + 1'b1 == CLEN[j_q]) ? '0 : c_ptr + 1'b1;
		off    = p15[11:0];
		pos0   = $signed({2'b00, c_ptr, 8'h00}) + 22'(off);
		span   = $signed({2'b00, CLEN[j_q], 8'h00});
		if (pos0 < 0) begin
			pos = pos0 + span;
		end else if (pos0 >= span) begin
			pos = pos0 - span;
		end else begin
			pos = pos0;
		end
		ia_n = pos[19:8];
		ib_n = (ia_n + 1'b1 == CLEN[j_q]) ? '0 : ia_n + 1'b1;
		lpn  = sat(ACC_W'(rd_q) + p16);

		tmag = tacc_q[SUM_W-1] ? -tacc_q : tacc_q;
		tq   = tacc_q[SUM_W-1] ? -(prod >>> DIV6_SHIFT) : (prod >>> DIV6_SHIFT);
		wet  = p16 + ACC_W'(ap_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:   if (last_clr) state_d = ST_IDLE;
			ST_IDLE:    if (in_valid) state_d = ST_FB_W;
			ST_FB_W:    if (!mul_busy) state_d = ST_E_RD;
			ST_E_RD:    state_d = ST_E_W;
			ST_E_W: begin
				if (!mul_busy) state_d = (j_q == 3'(EARLY_TAPS - 1)) ? ST_A_RD : ST_E_RD;
			end
			ST_A_RD:    state_d = ST_A_D;
			ST_A_D:     state_d = ST_A_W1;
			ST_A_W1:    if (!mul_busy) state_d = ST_A_W2;
			ST_A_W2: begin
				if (!mul_busy) begin
					priority if (k_q == 2'd1) state_d = ST_C_SIN;
					else if (k_q == 2'd2) state_d = ST_M_EL_W;
					else state_d = ST_A_RD;
				end
			end
			ST_C_SIN:   state_d = ST_C_SIN_W;
			ST_C_SIN_W: if (!mul_busy) state_d = ST_C_OFF_W;
			ST_C_OFF_W: if (!mul_busy) state_d = ST_C_RDA;
			ST_C_RDA:   state_d = ST_C_RDB;
			ST_C_RDB:   state_d = ST_C_INT;
			ST_C_INT:   state_d = ST_C_INT_W;
			ST_C_INT_W: if (!mul_busy) state_d = ST_C_LP_W;
			ST_C_LP_W:  if (!mul_busy) state_d = ST_C_FB_W;
			ST_C_FB_W: begin
				if (!mul_busy) state_d = (j_q == 3'(COMB_COUNT - 1)) ? ST_T_DIV_W : ST_C_SIN;
			end
			ST_T_DIV_W: if (!mul_busy) state_d = ST_A_RD;
			ST_M_EL_W:  if (!mul_busy) state_d = ST_M_MIX_W;
			ST_M_MIX_W: if (!mul_busy) state_d = ST_M_OUT;
			ST_M_OUT:   if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		mul_req    = '0;
		e_we       = 1'b0;
		e_waddr    = e_raddr;
		e_wdata    = sat(p16);
		c_we       = 1'b0;
		c_waddr    = CBASE[j_q] + CA_W'(c_ptr);
		c_wdata    = sat(ACC_W'(ap_q) + p16);
		c_raddr    = CBASE[j_q] + CA_W'(ia_q);
		d_we       = 1'b0;
		d_waddr    = d_raddr;
		d_wdata    = sat(ACC_W'(ap_q) + p16);
		res.load   = 1'b0;
		res.sample = sat(ACC_W'(x_q) + p16);
		unique case (state_q)
			ST_CLEAR: begin
				e_we    = 1'b1;
				e_waddr = EA_W'(clr_q);
				e_wdata = '0;
				c_we    = (clr_q < CLR_W'(COMB_DEPTH));
				c_waddr = CA_W'(clr_q);
				c_wdata = '0;
				d_we    = (clr_q < CLR_W'(DIFF_DEPTH));
				d_waddr = clr_q[DA_W-1:0];
				d_wdata = '0;
			end
			ST_IDLE: begin
				mul_req = '{in_valid, ACC_W'($signed({1'b0, cfg.room_size})), ROOM_MUL, 6'd15};
			end
			ST_E_RD: begin
				mul_req = '{1'b1, ACC_W'(x_q), EATT[j_q], 6'd16};
			end
			ST_E_W: begin
				e_we = !mul_busy;
			end
			ST_A_D: begin
				mul_req = '{1'b1, ACC_W'(ap_q) - ACC_W'($signed(d_rdata)),
					MB_W'(cfg.allpass_gain), 6'd16};
			end
			ST_A_W1: begin
				mul_req = '{!mul_busy, ACC_W'(d_q), MB_W'(cfg.allpass_gain), 6'd16};
			end
			ST_A_W2: begin
				d_we    = !mul_busy;
				mul_req = '{!mul_busy && (k_q == 2'd2), ACC_W'(early_q),
					MB_W'(cfg.early_level), 6'd16};
			end
			ST_C_SIN: begin
				mul_req = '{1'b1, ACC_W'(sdiff), MB_W'(sfrac), 6'd16};
			end
			ST_C_SIN_W: begin
				mul_req = '{!mul_busy, ACC_W'(ssin), MB_W'(cfg.mod_depth), 6'd10};
			end
			ST_C_RDB, ST_C_INT: begin
				c_raddr = CBASE[j_q] + CA_W'(ib_q);
				mul_req = '{state_q == ST_C_INT, ACC_W'($signed(c_rdata)) - ACC_W'(a_q),
					MB_W'(fr_q), 6'd8};
			end
			ST_C_INT_W: begin
				c_raddr = CBASE[j_q] + CA_W'(ib_q);
				mul_req = '{!mul_busy, ACC_W'(lp_q[j_q]) - ACC_W'(SW'(rd_q + SW'(p8)) - rd_q + a_q - a_q) * 0 +
					ACC_W'(lp_q[j_q]) - ACC_W'(a_q) - p8 - ACC_W'(lp_q[j_q]),
					MB_W'(cfg.damping[15:1]), 6'd15};
			end
			ST_C_LP_W: begin
				mul_req = '{!mul_busy, ACC_W'(lpn), MB_W'(fb_q), 6'd16};
			end
			ST_C_FB_W: begin
				c_we    = !mul_busy;
				mul_req = '{!mul_busy && (j_q == 3'(COMB_COUNT - 1)),
					ACC_W'(tacc_q[SUM_W-1] ? -(tacc_q + SUM_W'($signed(rd_q)) * 0) : tacc_q) * 0 +
					ACC_W'(tmag), DIV6_RECIP, 6'd27};
			end
			ST_M_EL_W: begin
				mul_req = '{!mul_busy, wet - ACC_W'(x_q), MB_W'(cfg.dry_wet), 6'd16};
			end
			ST_M_OUT: begin
				res.load = out_free;
			end
			default: begin
				mul_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			j_q     <= '0;
			k_q     <= '0;
			for (int i = 0; i < EARLY_TAPS; i++) eptr_q[i] <= '0;
			for (int i = 0; i < COMB_COUNT; i++) begin
				cptr_q[i] <= '0;
				lp_q[i]   <= '0;
				ph_q[i]   <= LFO_INIT[i];
			end
			for (int i = 0; i < DIFF_COUNT; i++) dptr_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (accept) begin
				j_q <= '0;
				k_q <= '0;
			end
			if (state_q == ST_E_W && !mul_busy) begin
				eptr_q[j_q] <= e_nptr;
				j_q         <= (j_q == 3'(EARLY_TAPS - 1)) ? '0 : j_q + 1'b1;
			end
			if (state_q == ST_A_W2 && !mul_busy) begin
				dptr_q[k_q] <= d_nptr;
				if (k_q == 2'd0) k_q <= 2'd1;
			end
			if (state_q == ST_C_INT_W && !mul_busy) begin
				ph_q[j_q] <= ph_q[j_q] + cfg.mod_step;
			end
			if (state_q == ST_C_LP_W && !mul_busy) lp_q[j_q] <= lpn;
			if (state_q == ST_C_FB_W && !mul_busy) begin
				cptr_q[j_q] <= c_nptr;
				j_q         <= (j_q == 3'(COMB_COUNT - 1)) ? '0 : j_q + 1'b1;
			end
			if (state_q == ST_T_DIV_W && !mul_busy) k_q <= 2'd2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= sample_in;
			eacc_q <= '0;
			tacc_q <= '0;
		end
		unique case (state_q)
			ST_FB_W: if (!mul_busy) fb_q <= 16'(p16 + ACC_W'(FB_BASE));
			ST_E_W: begin
				if (!mul_busy) begin
					eacc_q <= esum;
					if (j_q == 3'(EARLY_TAPS - 1)) begin
						early_q <= eavg;
						ap_q    <= AP_W'(x_q);
					end
				end
			end
			ST_A_D:  d_q <= $signed(d_rdata);
			ST_A_W1: if (!mul_busy) y_q <= AP_W'(yn);
			ST_A_W2: if (!mul_busy) ap_q <= y_q;
			ST_C_OFF_W: begin
				if (!mul_busy) begin
					ia_q <= ia_n;
					ib_q <= ib_n;
					fr_q <= pos[7:0];
				end
			end
			ST_C_RDB: a_q <= $signed(c_rdata);
			ST_C_INT_W: begin
				if (!mul_busy) begin
					rd_q   <= SW'(ACC_W'(a_q) + p8);
					tacc_q <= tacc_q + SUM_W'(ACC_W'(a_q) + p8);
				end
			end
			ST_T_DIV_W: if (!mul_busy) ap_q <= AP_W'(tq);
			default: begin
			end
		endcase
	end

	`MCAR_ASSERT_IMP(a_mul_free, clk, arst_n, mul_req.start, !mul_busy)
	`MCAR_ASSERT_IMP(a_early_addr, clk, arst_n, e_we, e_waddr < EA_W'(EARLY_DEPTH))
	`MCAR_ASSERT_IMP(a_comb_addr, clk, arst_n, c_we, c_waddr < CA_W'(COMB_DEPTH))
	`MCAR_ASSERT_NXT(a_load_idle, clk, arst_n, res.load, state_q == ST_IDLE)

endmodule

### hdl/modulated_comb_allpass_reverb_core.sv
// Modulated comb/allpass reverb, one Q1.23 sample in, one mixed sample out.
// Input channel: in_valid / in_stall with sample_in; a sample transfers when
// in_valid is high and in_stall is low. Output channel: out_valid / out_stall
// with sample_out, held in an output register until the receiver transfers it.
// Configuration: cfg_we writes cfg_data to the register at cfg_index
// (0 room_size .. 6 mod_step); unused bits and index 7 are dropped.
// Every product runs through one bit-serial multiplier, one coefficient bit
// per cycle, and the delay lines sit in three single-port-write RAMs. Per
// sample the core runs 8 early taps, 3 allpasses and 6 combs, plus mix and
// divide, between its transfer and its result.
// A new sample is taken as soon as the previous result is in the output
// register, even while out_stall holds that result.
// After reset the core clears all delay lines with in_stall held
// high; configuration writes are taken throughout. Registers return to
// their reset values, LFO phases start at even sixths of a turn.
// While out_stall is high the finished result is held and the next sample
// stops at its last step until the output register frees.
module modulated_comb_allpass_reverb_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [mcar_pkg::SW-1:0]        sample_in,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [mcar_pkg::SW-1:0]        sample_out,
	input  logic                                  cfg_we,
	input  logic [mcar_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mcar_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import mcar_pkg::*;

	cfg_t                 cfg_q;
	res_t                 res;
	logic                 out_valid_q;
	logic signed [SW-1:0] sample_out_q;
	logic                 out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.room_size    <= 16'd32768;
			cfg_q.dry_wet      <= 16'd0;
			cfg_q.damping      <= 16'd32768;
			cfg_q.early_level  <= 16'd9830;
			cfg_q.allpass_gain <= 16'd32768;
			cfg_q.mod_depth    <= 10'd512;
			cfg_q.mod_step     <= 32'd26844;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROOM_SIZE:    cfg_q.room_size    <= cfg_data[15:0];
				CFG_DRY_WET:      cfg_q.dry_wet      <= cfg_data[15:0];
				CFG_DAMPING:      cfg_q.damping      <= cfg_data[15:0];
				CFG_EARLY_LEVEL:  cfg_q.early_level  <= cfg_data[15:0];
				CFG_ALLPASS_GAIN: cfg_q.allpass_gain <= cfg_data[15:0];
				CFG_MOD_DEPTH:    cfg_q.mod_depth    <= cfg_data[9:0];
				CFG_MOD_STEP:     cfg_q.mod_step     <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	mcar_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample_in (sample_in),
		.out_free  (out_free),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) sample_out_q <= res.sample;
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

endmodule
